FILE: rtl/ubxfr_pkg.sv
`timescale 1ns / 1ps

package ubxfr_pkg;

   localparam logic [7:0]  SYNC_FIRST        = 8'hB5;
   localparam logic [7:0]  SYNC_SECOND       = 8'h62;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;
   localparam int          QUEUE_DEPTH       = 4;

   typedef enum logic [2:0] {
      KIND_DATA     = 3'd0,
      KIND_GOOD     = 3'd1,
      KIND_BAD_SUM  = 3'd2,
      KIND_TOO_LONG = 3'd3,
      KIND_TRUNC    = 3'd4
   } kind_type;

   typedef enum logic [8:0] {
      PH_HUNT    = 9'b000000001,
      PH_SYNC2   = 9'b000000010,
      PH_CLASS   = 9'b000000100,
      PH_ID      = 9'b000001000,
      PH_LEN_LO  = 9'b000010000,
      PH_LEN_HI  = 9'b000100000,
      PH_PAYLOAD = 9'b001000000,
      PH_CK_A    = 9'b010000000,
      PH_CK_B    = 9'b100000000
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [15:0] payload_length;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
   } result_type;

endpackage

FILE: rtl/ubx_frame_receiver_top.sv
`timescale 1ns / 1ps

// Receiver for UBX frames, fed one received byte per item on the req_ channel
// (req_tdata is the byte, req_tlast marks the last byte of a receive buffer).
// Each item yields zero or one result on the rsp_ channel: a payload byte with
// its index, frame good, checksum error, length too long or truncated, with
// the kind on rsp_tuser and the frame's class, id and length in rsp_tdata.
// The max_payload limit is written through csr_wr_en / csr_wr_data while idle;
// the user must ensure this, as the block does not enforce it. Throughput is
// one byte per cycle while the result queue (QueueDepth entries) has space. A
// result enters the queue as its byte is accepted and reaches rsp_ once the
// entries ahead of it drain. When the receiver holds rsp_tready low and the
// queue fills, req_tready drops until an entry drains, and no byte is lost.
// Reset returns the parser to hunting for the sync pair, empties the queue and
// sets max_payload to 1024; with no clearing pass, bytes are taken at once.
module ubx_frame_receiver_top #(
   parameter int QueueDepth = ubxfr_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,   // end_of_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] msg_class, [15:8] msg_id, [31:16] payload_length,
                                    // [39:32] data_byte, [55:40] byte_index
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data  // [15:0] max_payload
);
   import ubxfr_pkg::*;

   logic [15:0] max_payload_ff;
   logic        queue_space;
   logic        res_push;
   result_type  res_data;
   result_type  out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_wr_en) begin
         max_payload_ff <= csr_wr_data;
      end
   end

   ubxfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_byte     (req_tdata),
      .in_last     (req_tlast),
      .in_ready    (req_tready),
      .max_payload (max_payload_ff),
      .queue_space (queue_space),
      .res_push    (res_push),
      .res_data    (res_data)
   );

   ubxfr_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .space     (queue_space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tuser = out_data.kind;
   assign rsp_tdata = {out_data.byte_index, out_data.data_byte, out_data.payload_length,
                       out_data.msg_id, out_data.msg_class};

endmodule

FILE: rtl/ubxfr_parser.sv
`timescale 1ns / 1ps

module ubxfr_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   output logic                 in_ready,
   input  logic [15:0]          max_payload,
   input  logic                 queue_space,
   output logic                 res_push,
   output ubxfr_pkg::result_type res_data
);
   import ubxfr_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] seen_ff, seen_in;
   logic [7:0]  rx_sum_a_ff, rx_sum_a_in;

   logic        accept;
   logic [7:0]  add_a;
   logic [7:0]  add_b;
   logic [15:0] full_length;
   logic [15:0] seen_next;
   logic        have;
   logic        done;
   kind_type    kind;
   logic [7:0]  data;
   logic [15:0] index;
   logic        in_frame;

   assign in_ready = queue_space;
   assign accept   = in_valid & queue_space;

   assign add_a       = sum_a_ff + in_byte;
   assign add_b       = sum_b_ff + add_a;
   assign full_length = {in_byte, length_ff[7:0]};
   assign seen_next   = seen_ff + 16'd1;

   always_comb begin
      phase_in    = phase_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      class_in    = class_ff;
      id_in       = id_ff;
      length_in   = length_ff;
      seen_in     = seen_ff;
      rx_sum_a_in = rx_sum_a_ff;
      have        = 1'b0;
      done        = 1'b0;
      kind        = KIND_DATA;
      data        = 8'd0;
      index       = 16'd0;
      case (phase_ff)
         PH_SYNC2: begin
            if (in_byte == SYNC_SECOND) begin
               phase_in    = PH_CLASS;
               sum_a_in    = 8'd0;
               sum_b_in    = 8'd0;
               class_in    = 8'd0;
               id_in       = 8'd0;
               length_in   = 16'd0;
               seen_in     = 16'd0;
               rx_sum_a_in = 8'd0;
            end else if (in_byte != SYNC_FIRST) begin
               phase_in = PH_HUNT;
            end
         end
         PH_CLASS: begin
            class_in = in_byte;
            sum_a_in = add_a;
            sum_b_in = add_b;
            phase_in = PH_ID;
         end
         PH_ID: begin
            id_in    = in_byte;
            sum_a_in = add_a;
            sum_b_in = add_b;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = {8'd0, in_byte};
            sum_a_in  = add_a;
            sum_b_in  = add_b;
            phase_in  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_in = full_length;
            sum_a_in  = add_a;
            sum_b_in  = add_b;
            if (full_length > max_payload) begin
               have     = 1'b1;
               done     = 1'b1;
               kind     = KIND_TOO_LONG;
               phase_in = PH_HUNT;
            end else if (full_length == 16'd0) begin
               phase_in = PH_CK_A;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            sum_a_in = add_a;
            sum_b_in = add_b;
            have     = 1'b1;
            kind     = KIND_DATA;
            data     = in_byte;
            index    = seen_ff;
            seen_in  = seen_next;
            if (seen_next >= length_ff) begin
               phase_in = PH_CK_A;
            end
         end
         PH_CK_A: begin
            rx_sum_a_in = in_byte;
            phase_in    = PH_CK_B;
         end
         PH_CK_B: begin
            have     = 1'b1;
            done     = 1'b1;
            kind     = (rx_sum_a_ff == sum_a_ff && in_byte == sum_b_ff) ? KIND_GOOD
                                                                         : KIND_BAD_SUM;
            phase_in = PH_HUNT;
         end
         default: begin
            phase_in = (in_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
         end
      endcase

      // A buffer end inside a started frame abandons it and reports truncation.
      in_frame = (phase_in != PH_HUNT) && (phase_in != PH_SYNC2);
      if (in_last && !done) begin
         if (in_frame) begin
            have  = 1'b1;
            kind  = KIND_TRUNC;
            data  = 8'd0;
            index = 16'd0;
         end
         phase_in = PH_HUNT;
      end
   end

   assign res_push                = accept & have;
   assign res_data.kind           = kind;
   assign res_data.msg_class      = class_in;
   assign res_data.msg_id         = id_in;
   assign res_data.payload_length = length_in;
   assign res_data.data_byte      = data;
   assign res_data.byte_index     = index;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         sum_a_ff    <= 8'd0;
         sum_b_ff    <= 8'd0;
         class_ff    <= 8'd0;
         id_ff       <= 8'd0;
         length_ff   <= 16'd0;
         seen_ff     <= 16'd0;
         rx_sum_a_ff <= 8'd0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         sum_a_ff    <= sum_a_in;
         sum_b_ff    <= sum_b_in;
         class_ff    <= class_in;
         id_ff       <= id_in;
         length_ff   <= length_in;
         seen_ff     <= seen_in;
         rx_sum_a_ff <= rx_sum_a_in;
      end
   end

endmodule

FILE: rtl/ubxfr_queue.sv
`timescale 1ns / 1ps

module ubxfr_queue #(
   parameter int Depth = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ubxfr_pkg::result_type push_data,
   output logic                 space,
   output logic                 out_valid,
   input  logic                 out_ready,
   output ubxfr_pkg::result_type out_data
);
   import ubxfr_pkg::*;

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   result_type            entry_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  pop;

   assign space     = (count_ff != CountWidth'(Depth));
   assign out_valid = (count_ff != '0);
   assign pop       = out_valid & out_ready;
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: tb/ubx_frame_checker.sv
`timescale 1ns / 1ps

module ubx_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,   // end_of_buffer
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,   // [7:0] msg_class, [15:8] msg_id, [31:16] payload_length,
                                    // [39:32] data_byte, [55:40] byte_index
   input  logic [2:0]  rsp_tuser,   // [2:0] kind
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data, // [15:0] max_payload
   output int          fail_count,
   output int          outstanding
);
   import ubxfr_pkg::*;

   phase_type   phase;
   logic [7:0]  fletcher_a;
   logic [7:0]  fletcher_b;
   logic [7:0]  frame_class;
   logic [7:0]  frame_id;
   logic [15:0] frame_len;
   logic [15:0] payload_count;
   logic [7:0]  check_a_rx;
   logic [15:0] len_limit;
   result_type  expected_reports[$];

   initial begin
      fail_count = 0;
      outstanding = 0;
   end

   task automatic add_to_fletcher(input logic [7:0] value);
      fletcher_a = fletcher_a + value;
      fletcher_b = fletcher_b + fletcher_a;
   endtask

   task automatic check_field(input string name, input logic [15:0] want_v,
                              input logic [15:0] got_v);
      if (got_v !== want_v) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : frame_model
      logic       emit_now;
      logic       frame_over;
      result_type want;
      if (reset) begin
         phase = PH_HUNT;
         fletcher_a = '0;
         fletcher_b = '0;
         frame_class = '0;
         frame_id = '0;
         frame_len = '0;
         payload_count = '0;
         check_a_rx = '0;
         len_limit = MAX_PAYLOAD_RESET;
         expected_reports.delete();
      end else begin
         if (csr_wr_en) len_limit = csr_wr_data;

         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               $error("item on rsp_ with nothing expected: kind %0d, tdata %h",
                      rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_reports.pop_front();
               check_field("kind", 16'(want.kind), 16'(rsp_tuser));
               check_field("msg_class", 16'(want.msg_class), 16'(rsp_tdata[7:0]));
               check_field("msg_id", 16'(want.msg_id), 16'(rsp_tdata[15:8]));
               check_field("payload_length", want.payload_length, rsp_tdata[31:16]);
               check_field("data_byte", 16'(want.data_byte), 16'(rsp_tdata[39:32]));
               check_field("byte_index", want.byte_index, rsp_tdata[55:40]);
            end
         end

         if (req_tvalid && req_tready) begin
            emit_now = 1'b0;
            frame_over = 1'b0;
            want = '0;
            case (phase)
               PH_SYNC2: begin
                  if (req_tdata == SYNC_SECOND) begin
                     phase = PH_CLASS;
                     fletcher_a = '0;
                     fletcher_b = '0;
                     frame_class = '0;
                     frame_id = '0;
                     frame_len = '0;
                     payload_count = '0;
                     check_a_rx = '0;
                  end else if (req_tdata != SYNC_FIRST) begin
                     phase = PH_HUNT;
                  end
               end
               PH_CLASS: begin
                  frame_class = req_tdata;
                  add_to_fletcher(req_tdata);
                  phase = PH_ID;
               end
               PH_ID: begin
                  frame_id = req_tdata;
                  add_to_fletcher(req_tdata);
                  phase = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  frame_len = {8'h00, req_tdata};
                  add_to_fletcher(req_tdata);
                  phase = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  frame_len[15:8] = req_tdata;
                  add_to_fletcher(req_tdata);
                  if (frame_len > len_limit) begin
                     emit_now = 1'b1;
                     frame_over = 1'b1;
                     want.kind = KIND_TOO_LONG;
                     phase = PH_HUNT;
                  end else if (frame_len == 16'd0) begin
                     phase = PH_CK_A;
                  end else begin
                     phase = PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  add_to_fletcher(req_tdata);
                  emit_now = 1'b1;
                  want.kind = KIND_DATA;
                  want.data_byte = req_tdata;
                  want.byte_index = payload_count;
                  payload_count = payload_count + 16'd1;
                  if (payload_count >= frame_len) phase = PH_CK_A;
               end
               PH_CK_A: begin
                  check_a_rx = req_tdata;
                  phase = PH_CK_B;
               end
               PH_CK_B: begin
                  emit_now = 1'b1;
                  frame_over = 1'b1;
                  want.kind = (check_a_rx == fletcher_a && req_tdata == fletcher_b) ?
                              KIND_GOOD : KIND_BAD_SUM;
                  phase = PH_HUNT;
               end
               default: begin
                  phase = (req_tdata == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
               end
            endcase

            // A buffer end inside a frame replaces any payload item with truncation.
            if (req_tlast && !frame_over) begin
               if (phase != PH_HUNT && phase != PH_SYNC2) begin
                  emit_now = 1'b1;
                  want.kind = KIND_TRUNC;
                  want.data_byte = '0;
                  want.byte_index = '0;
               end
               phase = PH_HUNT;
            end

            if (emit_now) begin
               want.msg_class = frame_class;
               want.msg_id = frame_id;
               want.payload_length = frame_len;
               expected_reports.push_back(want);
            end
         end
      end
      outstanding = expected_reports.size();
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ubxfr_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] rx_byte
   logic        req_tlast;   // end_of_buffer
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;   // [7:0] msg_class, [15:8] msg_id, [31:16] payload_length,
                             // [39:32] data_byte, [55:40] byte_index
   logic [2:0]  rsp_tuser;   // [2:0] kind
   logic        csr_wr_en;
   logic [15:0] csr_wr_data; // [15:0] max_payload

   int          fail_count;
   int          outstanding;
   int          items_sent;
   bit          quiet_send;
   bit          quiet_recv;
   logic [15:0] cur_limit;

   ubx_frame_receiver_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ubx_frame_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Mostly no pause, often a short one, now and then a long one.
   function automatic int pause_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 65) return 0;
      if (pick < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [15:0] pick_length(input logic [15:0] limit);
      int pick;
      pick = $urandom_range(99);
      if (pick < 8 && limit != 16'hFFFF) return 16'($urandom_range(65535, limit + 1));
      if (pick < 12) return limit;
      if (pick < 18 && limit > 64) return 16'($urandom_range(limit, 65));
      if (limit < 12) return 16'($urandom_range(limit, 0));
      return 16'($urandom_range(12, 0));
   endfunction

   task automatic send_item(input logic [7:0] value, input logic last);
      int gap;
      gap = quiet_send ? 0 : pause_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= value;
      req_tlast <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   // Sends one frame with a random payload. A damaged frame has one bit flipped in its
   // payload or checksum. The buffer ends at byte position cut, if that lies in the frame.
   task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input bit damage, input int cut);
      logic [7:0] frame_bytes[$];
      logic [7:0] ck_a;
      logic [7:0] ck_b;
      int         spot;
      int         stop;
      frame_bytes.push_back(SYNC_FIRST);
      frame_bytes.push_back(SYNC_SECOND);
      frame_bytes.push_back(cls);
      frame_bytes.push_back(id);
      frame_bytes.push_back(len[7:0]);
      frame_bytes.push_back(len[15:8]);
      if (len <= cur_limit) begin
         repeat ((len > 64) ? 8 : len) frame_bytes.push_back(8'($urandom_range(255)));
         if (len > 64) begin
            // The declared payload is never completed, so the buffer has to end inside the frame.
            if (cut < 0 || cut >= frame_bytes.size()) cut = frame_bytes.size() - 1;
         end else begin
            ck_a = '0;
            ck_b = '0;
            for (int i = 2; i < frame_bytes.size(); i++) begin
               ck_a = ck_a + frame_bytes[i];
               ck_b = ck_b + ck_a;
            end
            frame_bytes.push_back(ck_a);
            frame_bytes.push_back(ck_b);
            if (damage) begin
               spot = $urandom_range(frame_bytes.size() - 1, 6);
               frame_bytes[spot] = frame_bytes[spot] ^ (8'h01 << $urandom_range(7));
            end
         end
      end
      stop = (cut >= 0 && cut < frame_bytes.size()) ? cut + 1 : frame_bytes.size();
      for (int i = 0; i < stop; i++) send_item(frame_bytes[i], i == cut);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      // Bytes that make no item may still be in the parser.
      repeat (8) @(negedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_limit = value;
   endtask

   initial begin
      int hold;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold == 0) hold = quiet_recv ? 0 : pause_length();
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int          pick;
      int          target;
      logic [15:0] setting;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      items_sent = 0;
      quiet_send = 1'b0;
      quiet_recv = 1'b0;
      cur_limit = MAX_PAYLOAD_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Repeated first sync byte ahead of a good frame.
      send_item(SYNC_FIRST, 1'b0);
      send_frame(8'hFF, 8'h00, 16'd2, 1'b0, -1);
      // Empty payload with a bad checksum, the buffer ending on the last checksum byte.
      send_frame(8'h00, 8'hFF, 16'd0, 1'b1, 7);
      // Too long, the buffer ending on the high length byte.
      send_frame(8'h0A, 8'h0B, 16'hFFFF, 1'b0, 5);
      // Buffer ends right after the class byte.
      send_frame(8'h33, 8'h44, 16'd3, 1'b0, 2);
      // A lone first sync byte at a buffer end is dropped.
      send_item(SYNC_FIRST, 1'b1);

      for (int p = 0; p < 7; p++) begin
         settle();
         case (p)
            0:       setting = 16'd0;
            1:       setting = 16'hFFFF;
            2:       setting = MAX_PAYLOAD_RESET;
            3:       setting = 16'd5;
            5:       setting = 16'd64;
            default: setting = 16'($urandom_range(65535));
         endcase
         write_limit(setting);
         quiet_send = ($urandom_range(3) == 0);
         quiet_recv = ($urandom_range(3) == 0);
         target = items_sent + 270;
         while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
               send_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
                          pick_length(cur_limit),
                          $urandom_range(7) == 0,
                          ($urandom_range(9) == 0) ? $urandom_range(15) : -1);
            end else if (pick < 90) begin
               repeat ($urandom_range(6, 1))
                  send_item(8'($urandom_range(255)), $urandom_range(15) == 0);
            end else begin
               send_item(SYNC_FIRST, 1'b0);
               repeat ($urandom_range(2)) send_item(SYNC_FIRST, 1'b0);
               send_item($urandom_range(1) ? SYNC_SECOND : 8'($urandom_range(255)),
                         $urandom_range(3) == 0);
            end
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: sim.f
rtl/ubxfr_pkg.sv
rtl/ubxfr_parser.sv
rtl/ubxfr_queue.sv
rtl/ubx_frame_receiver_top.sv
tb/ubx_frame_checker.sv
tb/testbench.sv
